FILE: src/ptt_pkg.sv
// package for the pressure task throttle picker
// holds sizes, opcodes, register indexes, reset values and the structs shared by the
// cell row and the top level; depends on nothing
`timescale 1ns / 1ps

package ptt_pkg;

	localparam int TABLE_DEPTH       = 16;
	localparam int MAX_ACTIONS_BOUND = 8;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int ACT_W = $clog2(MAX_ACTIONS_BOUND + 1);

	localparam int KEY_W  = 16;
	localparam int PROC_W = 31;
	localparam int TIME_W = 48;
	localparam int MEM_W  = 24;
	localparam int MAXA_W = 4;
	localparam int COOL_W = 32;
	localparam int CFGD_W = 32;
	localparam int CFGI_W = 2;

	localparam logic [MEM_W-1:0]  RST_MEM_THRESHOLD = MEM_W'(65536);
	localparam logic [MAXA_W-1:0] RST_MAX_ACTIONS   = MAXA_W'(2);
	localparam logic [COOL_W-1:0] RST_COOLDOWN      = COOL_W'(2000);

	typedef enum logic [1:0] {
		OP_START    = 2'd0,
		OP_FINISH   = 2'd1,
		OP_PRESSURE = 2'd2
	} opcode_t;

	typedef enum logic [CFGI_W-1:0] {
		REG_MEM_THRESHOLD = 2'd0,
		REG_MAX_ACTIONS   = 2'd1,
		REG_COOLDOWN      = 2'd2
	} reg_index_t;

	// message that walks down the cell row, one cell per cycle
	typedef struct packed {
		logic              live;
		logic              hit_found;
		logic [IDX_W-1:0]  hit_idx;
		logic              free_found;
		logic [IDX_W-1:0]  free_idx;
		logic              best_found;
		logic [IDX_W-1:0]  best_idx;
		logic [TIME_W-1:0] best_start;
		logic [KEY_W-1:0]  best_key;
		logic [PROC_W-1:0] best_proc;
		logic [CNT_W-1:0]  cand_cnt;
	} sweep_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic              wr_en;
		logic              clr_en;
		logic              taken_clr;
		logic              take_en;
		logic [IDX_W-1:0]  idx;
		logic [KEY_W-1:0]  key;
		logic [PROC_W-1:0] proc;
		logic [TIME_W-1:0] start;
	} cell_cmd_t;

endpackage

FILE: src/pressure_task_throttle_picker_unit.sv
// top level of the pressure task throttle picker: request port, config port,
// sequencer and the row of slot cells
// depends on ptt_pkg and ptt_cell
`timescale 1ns / 1ps

// Usage:
// A request is taken at a rising edge with start high and busy low; busy stays
// high until the request is fully handled. Config writes (cfg_valid, cfg_ready,
// cfg_index, cfg_data) are taken whenever cfg_valid is high, cfg_ready is tied
// high; write them only while busy is low. Index 3 is ignored.
// The table lives in a row of TABLE_DEPTH cells. Every search walks a message
// down the row, one cell per clock.
// Task start: one sweep, the write lands on its last edge. Task finish: busy
// only in the clear state. Unused opcode: no busy at all. Pressure: a check
// state, then one sweep per action; each result appears on result_strobe for
// one cycle at the end of its sweep, last_of_run marking the final one. Up to
// MAX_ACTIONS_BOUND results.
// Results are never held back: the receiver has to take each one in its cycle.
// Reset empties the table, clears the last action time and restores the
// register defaults (threshold 65536, max actions 2, cooldown 2000).

module pressure_task_throttle_picker_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  opcode,
	input  logic [ptt_pkg::KEY_W-1:0]   task_key,
	input  logic [ptt_pkg::PROC_W-1:0]  proc_id,
	input  logic [ptt_pkg::TIME_W-1:0]  time_ms,
	input  logic                        risk_high,
	input  logic [ptt_pkg::MEM_W-1:0]   mem_free_mb,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ptt_pkg::CFGI_W-1:0]  cfg_index,
	input  logic [ptt_pkg::CFGD_W-1:0]  cfg_data,
	output logic                        result_strobe,
	output logic [ptt_pkg::KEY_W-1:0]   victim_key,
	output logic [ptt_pkg::PROC_W-1:0]  victim_proc,
	output logic [ptt_pkg::TIME_W-1:0]  action_time_ms,
	output logic                        last_of_run
);
	import ptt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_CHECK,
		S_LAUNCH,
		S_SWEEP
	} state_t;

	state_t            state_q;
	logic [1:0]        op_q;
	logic [KEY_W-1:0]  key_q;
	logic [PROC_W-1:0] proc_q;
	logic [TIME_W-1:0] time_q;
	logic              risk_q;
	logic [MEM_W-1:0]  mem_q;
	logic [MEM_W-1:0]  thresh_q;
	logic [MAXA_W-1:0] max_act_q;
	logic [COOL_W-1:0] cool_q;
	logic [TIME_W-1:0] last_act_q;
	logic [ACT_W-1:0]  sent_q;
	logic [ACT_W-1:0]  limit_q;

	sweep_t            msg [TABLE_DEPTH+1];
	sweep_t            head;
	sweep_t            tail;
	cell_cmd_t         cmd;
	logic              accept;
	logic              is_high;
	logic              cool_ok;
	logic [TIME_W-1:0] elapsed;
	logic [ACT_W-1:0]  limit_d;
	logic              run_last;
	logic              tail_done;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign is_high = risk_q || (mem_q < thresh_q);
	assign elapsed = time_q - last_act_q;
	assign cool_ok = (time_q >= last_act_q) && (elapsed >= {(TIME_W-COOL_W)'(0), cool_q});
	assign limit_d = ({4'd0, max_act_q} > 8'(MAX_ACTIONS_BOUND)) ?
		ACT_W'(MAX_ACTIONS_BOUND) : ACT_W'(max_act_q);

	assign tail      = msg[TABLE_DEPTH];
	assign tail_done = (state_q == S_SWEEP) && tail.live;
	assign run_last  = ((sent_q + ACT_W'(1)) == limit_q) || (tail.cand_cnt == CNT_W'(1));

	// sweep is injected empty at the head of the row
	always_comb begin
		head      = '0;
		head.live = (state_q == S_LAUNCH);
	end

	assign msg[0] = head;

	always_comb begin
		cmd           = '0;
		cmd.key       = key_q;
		cmd.proc      = proc_q;
		cmd.start     = time_q;
		cmd.clr_en    = (state_q == S_CLEAR);
		cmd.taken_clr = (state_q == S_CHECK);
		if (op_q == OP_START) begin
			cmd.wr_en = tail_done && (tail.hit_found || tail.free_found);
			cmd.idx   = tail.hit_found ? tail.hit_idx : tail.free_idx;
		end else begin
			cmd.take_en = tail_done && tail.best_found;
			cmd.idx     = tail.best_idx;
		end
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		ptt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.my_idx  (IDX_W'(i)),
			.cmd     (cmd),
			.msg_in  (msg[i]),
			.msg_out (msg[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q  <= RST_MEM_THRESHOLD;
			max_act_q <= RST_MAX_ACTIONS;
			cool_q    <= RST_COOLDOWN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MEM_THRESHOLD: thresh_q  <= cfg_data[MEM_W-1:0];
				REG_MAX_ACTIONS:   max_act_q <= cfg_data[MAXA_W-1:0];
				REG_COOLDOWN:      cool_q    <= cfg_data[COOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			key_q  <= task_key;
			proc_q <= proc_id;
			time_q <= time_ms;
			risk_q <= risk_high;
			mem_q  <= mem_free_mb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			last_act_q     <= '0;
			sent_q         <= '0;
			limit_q        <= '0;
			result_strobe  <= 1'b0;
			victim_key     <= '0;
			victim_proc    <= '0;
			action_time_ms <= '0;
			last_of_run    <= 1'b0;
		end else begin
			result_strobe <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (opcode)
							OP_START:    state_q <= S_LAUNCH;
							OP_FINISH:   state_q <= S_CLEAR;
							OP_PRESSURE: state_q <= S_CHECK;
							default:     state_q <= S_IDLE;
						endcase
					end
				end
				S_CLEAR: state_q <= S_IDLE;
				S_CHECK: begin
					sent_q  <= '0;
					limit_q <= limit_d;
					if (is_high && cool_ok && (limit_d != '0)) begin
						state_q <= S_LAUNCH;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_LAUNCH: state_q <= S_SWEEP;
				S_SWEEP: begin
					if (tail.live) begin
						if ((op_q == OP_PRESSURE) && tail.best_found) begin
							result_strobe  <= 1'b1;
							victim_key     <= tail.best_key;
							victim_proc    <= tail.best_proc;
							action_time_ms <= time_q;
							last_of_run    <= run_last;
							last_act_q     <= time_q;
							sent_q         <= sent_q + ACT_W'(1);
							state_q        <= run_last ? S_IDLE : S_LAUNCH;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_result_from_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> ($past(state_q) == S_SWEEP))
		else $error("result outside a sweep");
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !last_of_run) |-> (state_q == S_LAUNCH))
		else $error("run ended without last flag");
	a_sent_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> (sent_q < limit_q || op_q != OP_PRESSURE))
		else $error("sweep beyond action limit");
	a_single_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LAUNCH) |=> !msg[0].live)
		else $error("second sweep injected");
`endif

endmodule

FILE: src/ptt_cell.sv
// one table slot of the throttle picker: holds a task entry and its taken mark,
// and folds its entry into the sweep message passed on to the next cell
// depends on ptt_pkg
`timescale 1ns / 1ps

module ptt_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ptt_pkg::IDX_W-1:0]  my_idx,
	input  ptt_pkg::cell_cmd_t         cmd,
	input  ptt_pkg::sweep_t            msg_in,
	output ptt_pkg::sweep_t            msg_out
);
	import ptt_pkg::*;

	logic              valid_q;
	logic              taken_q;
	logic [KEY_W-1:0]  key_q;
	logic [PROC_W-1:0] proc_q;
	logic [TIME_W-1:0] start_q;
	sweep_t            msg_q;
	sweep_t            msg_d;
	logic              key_match;
	logic              cand;

	assign key_match = valid_q && (key_q == cmd.key);
	assign cand      = valid_q && !taken_q;

	always_comb begin
		msg_d = msg_in;
		if (!msg_in.hit_found && key_match) begin
			msg_d.hit_found = 1'b1;
			msg_d.hit_idx   = my_idx;
		end
		if (!msg_in.free_found && !valid_q) begin
			msg_d.free_found = 1'b1;
			msg_d.free_idx   = my_idx;
		end
		if (cand) begin
			msg_d.cand_cnt = msg_in.cand_cnt + CNT_W'(1);
			// strict compare keeps the lower slot on equal start times
			if (!msg_in.best_found || (start_q > msg_in.best_start)) begin
				msg_d.best_found = 1'b1;
				msg_d.best_idx   = my_idx;
				msg_d.best_start = start_q;
				msg_d.best_key   = key_q;
				msg_d.best_proc  = proc_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			taken_q <= 1'b0;
			msg_q   <= '0;
		end else begin
			msg_q <= msg_d;
			if (cmd.wr_en && (cmd.idx == my_idx)) begin
				valid_q <= 1'b1;
			end else if (cmd.clr_en && key_match) begin
				valid_q <= 1'b0;
			end
			if (cmd.taken_clr) begin
				taken_q <= 1'b0;
			end else if (cmd.take_en && (cmd.idx == my_idx)) begin
				taken_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && (cmd.idx == my_idx)) begin
			key_q   <= cmd.key;
			proc_q  <= cmd.proc;
			start_q <= cmd.start;
		end
	end

	assign msg_out = msg_q;

`ifndef SYNTHESIS
	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_en && (cmd.idx == my_idx)) |=> valid_q)
		else $error("written slot not valid");
	a_taken_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.taken_clr |=> !taken_q)
		else $error("taken mark survived clear");
	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cand |=> (msg_q.cand_cnt == $past(msg_in.cand_cnt) + CNT_W'(1)))
		else $error("candidate count not advanced");
`endif

endmodule
